@@ rtl/core/radc_pkg.sv @@
// Package for the radix digit converter core.
// Holds base selector codes, shared struct types and the digit-to-ASCII function.
// No dependencies.
package radc_pkg;

    localparam logic [2:0] BASE_SEL_2  = 3'd0;
    localparam logic [2:0] BASE_SEL_3  = 3'd1;
    localparam logic [2:0] BASE_SEL_4  = 3'd2;
    localparam logic [2:0] BASE_SEL_8  = 3'd3;
    localparam logic [2:0] BASE_SEL_16 = 3'd4;

    localparam int VALUE_W = 31;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    // Reciprocal of three scaled by two to the 33rd, rounded up.
    localparam logic [32:0] RECIP3     = 33'h0AAAAAAAB;
    localparam int          RECIP3_SHR = 33;

    typedef struct packed {
        logic       mul_en;
        logic [2:0] base_sel;
    } div_ctl_t;

    typedef struct packed {
        logic [VALUE_W-1:0] quo;
        logic [DIGIT_W-1:0] rem;
    } div_res_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= 4'd9)
            c = 7'h30 + {3'b000, d};
        else
            c = 7'h41 + {3'b000, d} - 7'd10;
        return c;
    endfunction

endpackage

@@ rtl/core/radc_divider.sv @@
// Shared divide-by-base unit: one quotient and remainder per step.
// Base three uses a registered reciprocal product; powers of two use shifts.
// Depends on radc_pkg.
module radc_divider
(
    input  logic                        clk,
    input  radc_pkg::div_ctl_t          ctl,
    input  logic [radc_pkg::VALUE_W-1:0] q,
    output radc_pkg::div_res_t          res
);
    import radc_pkg::*;

    logic [63:0]        prod_reg;
    logic [63:0]        prod_next;
    logic [VALUE_W-1:0] quo3;
    logic [32:0]        quo3_x3;
    logic [32:0]        rem3;

    assign prod_next = {33'b0, q} * {31'b0, RECIP3};

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg <= prod_next;
    end

    assign quo3    = prod_reg[RECIP3_SHR +: VALUE_W];
    assign quo3_x3 = {2'b00, quo3} + {1'b0, quo3, 1'b0};
    assign rem3    = {2'b00, q} - quo3_x3;

    always_comb
    begin
        case (ctl.base_sel)
            BASE_SEL_3:
            begin
                res.quo = quo3;
                res.rem = {2'b00, rem3[1:0]};
            end
            BASE_SEL_4:
            begin
                res.quo = q >> 2;
                res.rem = {2'b00, q[1:0]};
            end
            BASE_SEL_8:
            begin
                res.quo = q >> 3;
                res.rem = {1'b0, q[2:0]};
            end
            BASE_SEL_16:
            begin
                res.quo = q >> 4;
                res.rem = q[3:0];
            end
            default:
            begin
                res.quo = q >> 1;
                res.rem = {3'b000, q[0]};
            end
        endcase
    end

endmodule

@@ rtl/core/radc_digit_store.sv @@
// Digit store: one write port and one registered read port.
// Depends on radc_pkg.
module radc_digit_store
#(
    parameter int DEPTH = 32
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [radc_pkg::DIGIT_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [radc_pkg::DIGIT_W-1:0] rd_data
);
    import radc_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/radix_digit_converter_core.sv @@
// Top level of the radix digit converter: sequencer, divider and digit store.
// Depends on radc_pkg, radc_divider and radc_digit_store.
//
//   channel | signals                                   | direction
//   input   | in_valid, in_ready, value, base_sel       | in
//   output  | out_valid, out_ready, digit_char, last, error | out
//
// An item passes through the shared divider a digit at a time: S_DIV alone for
// bases 2, 4, 8 and 16, S_MUL then S_DIV for base 3. Each digit is then read from
// the store (S_RD) and loaded into the output register (S_EMIT); rejects use S_ERR.
// Reset clears the sequencer and the output valid; the store needs no clearing.
// A stalled output holds the sequencer in its emit state until the item is taken.
module radix_digit_converter_core
#(
    parameter int DIGIT_DEPTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [radc_pkg::VALUE_W-1:0]  value,
    input  logic [2:0]                    base_sel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [radc_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last,
    output logic                          error
);
    import radc_pkg::*;

    localparam int AW = $clog2(DIGIT_DEPTH);
    localparam int CW = $clog2(DIGIT_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [VALUE_W-1:0] quot_reg, quot_next;
    logic [2:0]         base_reg, base_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               error_reg, error_next;

    div_ctl_t           div_ctl;
    div_res_t           div_res;
    logic               wr_en;
    logic               rd_en;
    logic [CW-1:0]      count_m1;
    logic [CW-1:0]      count_p1;
    logic [DIGIT_W-1:0] rd_data;
    logic               out_free;
    logic               accept;

    assign count_m1 = count_reg - CW'(1);
    assign count_p1 = count_reg + CW'(1);
    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign div_ctl.mul_en   = (state_reg == S_MUL);
    assign div_ctl.base_sel = base_reg;

    radc_divider u_div
    (
        .clk (clk),
        .ctl (div_ctl),
        .q   (quot_reg),
        .res (div_res)
    );

    radc_digit_store #(.DEPTH(DIGIT_DEPTH)) u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (div_res.rem),
        .rd_en   (rd_en),
        .rd_addr (count_m1[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        base_next      = base_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    quot_next  = value;
                    base_next  = base_sel;
                    count_next = '0;
                    if (value == '0 || base_sel > BASE_SEL_16)
                        state_next = S_ERR;
                    else if (base_sel == BASE_SEL_3)
                        state_next = S_MUL;
                    else
                        state_next = S_DIV;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                wr_en      = 1'b1;
                quot_next  = div_res.quo;
                count_next = count_p1;
                if (div_res.quo == '0 || count_p1 == CW'(DIGIT_DEPTH))
                    state_next = S_RD;
                else if (base_reg == BASE_SEL_3)
                    state_next = S_MUL;
                else
                    state_next = S_DIV;
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                count_next = count_m1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_ascii(rd_data);
                    last_next      = (count_reg == '0);
                    error_next     = 1'b0;
                    state_next     = (count_reg == '0) ? S_IDLE : S_RD;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = '0;
                    last_next      = 1'b1;
                    error_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            quot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            quot_reg      <= quot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        error_reg <= error_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;
    assign error      = error_reg;

endmodule

@@ rtl/core/radc_checker.sv @@
// Port-level checks for the radix digit converter core, bound to the top level.
// Depends on radix_digit_converter_core.
module radc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] digit_char,
    input logic       last,
    input logic       error
);

    // A result held back by the consumer keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char)
            && $stable(last) && $stable(error))
        else $error("output item changed while stalled");

    // An error result is a single item with no character.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> digit_char == 7'd0 && last)
        else $error("malformed error item");

    // Digit results carry a valid hexadecimal character.
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |->
            (digit_char >= 7'h30 && digit_char <= 7'h39)
            || (digit_char >= 7'h41 && digit_char <= 7'h46))
        else $error("digit item out of range");

    // The block is busy in the cycle after it takes an item.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // While ready for a new item, any pending result closes the previous run.
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("run left open while idle");

endmodule

bind radix_digit_converter_core radc_checker u_radc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last),
    .error      (error)
);
